[hw/rtl/pbc_pkg.sv]
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types, constants and helpers for the particle box collision step core.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int unsigned MaxSubsteps = 8;
  localparam int unsigned SubCntW     = $clog2(MaxSubsteps + 1);

  // Coordinates and velocities: signed Q5.10.
  localparam int unsigned CoordW = 16;
  // Wide working values.
  localparam int unsigned WideW  = 40;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] CfgBoxLow   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBoxHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRadius   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGravity  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRest     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgFriction = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgDrag     = 3'd6;

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    OpNone    = 4'd0,
    OpLoad    = 4'd1,
    OpStart   = 4'd2,
    OpAcc     = 4'd3,
    OpVel     = 4'd4,
    OpPos     = 4'd5,
    OpHit     = 4'd6,
    OpDivInit = 4'd7,
    OpDivStep = 4'd8,
    OpDt      = 4'd9,
    OpCont    = 4'd10,
    OpResp    = 4'd11,
    OpFree    = 4'd12
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;
  } pbc_cmd_t;

  typedef struct packed {
    logic hit;
    logic time_left;
    logic div_done;
  } pbc_sts_t;

  function automatic logic signed [WideW-1:0] round_shr(
      input logic signed [WideW-1:0] x, input int unsigned s);
    logic signed [WideW-1:0] t;
    t = x + (WideW'(1) <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [WideW-1:0] x);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'((64'sd1 <<< (CoordW - 1)) - 1);
    lo = -hi - WideW'(1);
    if (x > hi) begin
      return hi[CoordW-1:0];
    end else if (x < lo) begin
      return lo[CoordW-1:0];
    end
    return x[CoordW-1:0];
  endfunction

endpackage

[hw/rtl/pbc_ctrl.sv]
// ----------------------------------------------------------------------------
// pbc_ctrl
// Controller: sequences load, Euler substeps, hit test, division and response.
// ----------------------------------------------------------------------------
module pbc_ctrl import pbc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_func_i,
  output logic     in_ready_o,
  output logic     out_load_o,
  input  logic     out_busy_i,
  output pbc_cmd_t cmd_o,
  input  pbc_sts_t sts_i
);

  typedef enum logic [10:0] {
    StIdle  = 11'b000_0000_0001,
    StAcc   = 11'b000_0000_0010,
    StVel   = 11'b000_0000_0100,
    StPos   = 11'b000_0000_1000,
    StHit   = 11'b000_0001_0000,
    StDivI  = 11'b000_0010_0000,
    StDivS  = 11'b000_0100_0000,
    StDt    = 11'b000_1000_0000,
    StCont  = 11'b001_0000_0000,
    StResp  = 11'b010_0000_0000,
    StDone  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [SubCntW-1:0] sub_q, sub_d;
  logic [1:0] ax_q, ax_d;

  assign in_ready_o = (state_q == StIdle) && !out_busy_i;

  always_comb begin
    state_d = state_q;
    sub_d = sub_q;
    ax_d = ax_q;
    cmd_o.op = OpNone;
    cmd_o.axis = ax_q;
    out_load_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          sub_d = '0;
          if (in_func_i) begin
            cmd_o.op = OpLoad;
            state_d = StDone;
          end else begin
            cmd_o.op = OpStart;
            state_d = StAcc;
          end
        end
      end
      StAcc: begin
        if (!sts_i.time_left || sub_q == SubCntW'(MaxSubsteps)) begin
          state_d = StDone;
        end else begin
          cmd_o.op = OpAcc;
          sub_d = sub_q + SubCntW'(1);
          state_d = StVel;
        end
      end
      StVel: begin
        cmd_o.op = OpVel;
        state_d = StPos;
      end
      StPos: begin
        cmd_o.op = OpPos;
        state_d = StHit;
      end
      StHit: begin
        cmd_o.op = OpHit;
        state_d = StDivI;
      end
      StDivI: begin
        if (sts_i.hit) begin
          cmd_o.op = OpDivInit;
          state_d = StDivS;
        end else begin
          cmd_o.op = OpFree;
          state_d = StDone;
        end
      end
      StDivS: begin
        cmd_o.op = OpDivStep;
        if (sts_i.div_done) begin
          state_d = StDt;
        end
      end
      StDt: begin
        cmd_o.op = OpDt;
        state_d = StCont;
      end
      StCont: begin
        cmd_o.op = OpCont;
        state_d = StResp;
      end
      StResp: begin
        cmd_o.op = OpResp;
        state_d = StAcc;
      end
      StDone: begin
        out_load_o = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sub_q <= '0;
      ax_q <= '0;
    end else begin
      state_q <= state_d;
      sub_q <= sub_d;
      ax_q <= ax_d;
    end
  end

  a_sub_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q <= SubCntW'(MaxSubsteps)) else $error("substep count overflow");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StIdle) else $error("ready outside idle");
  a_done_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone |-> out_load_o) else $error("done without result load");

endmodule

[hw/rtl/pbc_dp.sv]
// ----------------------------------------------------------------------------
// pbc_dp
// Datapath: state vectors, Euler update, face test, radix-2 fraction divider.
// ----------------------------------------------------------------------------
module pbc_dp import pbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  pbc_cmd_t            cmd_i,
  output pbc_sts_t            sts_o,
  input  logic [15:0]         time_step_i,
  input  logic [95:0]         load_i,
  output logic [95:0]         state_o,
  output logic [5:0]          faces_o,
  output logic                limit_o
);

  logic [47:0] box_low_q, box_high_q, grav_q;
  logic [13:0] radius_q, drag_q;
  logic [10:0] rest_q, fric_q;

  logic signed [CoordW-1:0] pos_q [3];
  logic signed [CoordW-1:0] vel_q [3];
  logic signed [WideW-1:0] acc_q [3];
  logic signed [CoordW-1:0] vn_q [3];
  logic signed [WideW-1:0] cn_q [3];
  logic [16:0] hrem_q;
  logic [5:0] faces_q;
  logic [2:0] face_q;
  logic hit_q;
  logic signed [WideW-1:0] num_q, den_q;
  logic [WideW+16:0] rem_q;
  logic [WideW-1:0] dvs_q;
  logic [16:0] quo_q;
  logic [5:0] dcnt_q;
  logic [16:0] frac_q;
  logic [16:0] dt_q;
  logic dzero_q;
  logic signed [WideW-1:0] vc_q [3];
  logic signed [WideW-1:0] pc_q [3];

  function automatic logic signed [WideW-1:0] lane(input logic [47:0] r, input int a);
    logic [15:0] w;
    w = r[32-16*a +: 16];
    return WideW'($signed(w));
  endfunction

  logic signed [WideW-1:0] lo_w [3];
  logic signed [WideW-1:0] hi_w [3];
  logic signed [WideW-1:0] r_w;
  logic [10:0] rest_s, fric_s;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_w[a] = lane(box_low_q, a);
      hi_w[a] = lane(box_high_q, a);
    end
    r_w = WideW'($signed({1'b0, radius_q}));
    rest_s = (rest_q > 11'd1024) ? 11'd1024 : rest_q;
    fric_s = (fric_q > 11'd1024) ? 11'd1024 : fric_q;
  end

  // Face test on the free-flight center.
  logic [2:0] face_d;
  logic hit_d;
  always_comb begin
    hit_d = 1'b0;
    face_d = '0;
    for (int f = 0; f < 6; f++) begin
      if ((f % 2) == 1) begin
        if (cn_q[f/2] - lo_w[f/2] - r_w < 0) begin
          hit_d = 1'b1;
          face_d = 3'(f);
        end
      end else begin
        if (cn_q[f/2] - hi_w[f/2] + r_w > 0) begin
          hit_d = 1'b1;
          face_d = 3'(f);
        end
      end
    end
  end

  logic [1:0] ax;
  assign ax = face_q[2:1];

  logic [WideW+16:0] rem_sh;
  logic [WideW+16:0] rem_try;
  assign rem_sh = {rem_q[WideW+15:0], 1'b0};
  assign rem_try = rem_sh - {17'd0, dvs_q};

  assign sts_o.hit = hit_q;
  assign sts_o.time_left = (hrem_q != '0);
  assign sts_o.div_done = (dcnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_low_q <= '0;
      box_high_q <= 48'd65971704314880;
      radius_q <= 14'd1024;
      grav_q <= 48'd3637313536;
      rest_q <= 11'd973;
      fric_q <= 11'd102;
      drag_q <= 14'd1024;
      for (int a = 0; a < 3; a++) begin
        pos_q[a] <= '0;
        vel_q[a] <= '0;
      end
      faces_q <= '0;
      hrem_q <= '0;
      dcnt_q <= '0;
      limit_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgBoxLow:   box_low_q <= cfg_data_i;
          CfgBoxHigh:  box_high_q <= cfg_data_i;
          CfgRadius:   radius_q <= cfg_data_i[13:0];
          CfgGravity:  grav_q <= cfg_data_i;
          CfgRest:     rest_q <= cfg_data_i[10:0];
          CfgFriction: fric_q <= cfg_data_i[10:0];
          CfgDrag:     drag_q <= cfg_data_i[13:0];
          default: ;
        endcase
      end
      unique case (cmd_i.op)
        OpLoad: begin
          for (int a = 0; a < 3; a++) begin
            pos_q[a] <= load_i[16*a +: 16];
            vel_q[a] <= load_i[48+16*a +: 16];
          end
          faces_q <= '0;
          limit_o <= 1'b0;
          hrem_q <= '0;
        end
        OpStart: begin
          hrem_q <= {1'b0, time_step_i};
          faces_q <= '0;
          limit_o <= 1'b0;
        end
        OpAcc: begin
          for (int a = 0; a < 3; a++) begin
            acc_q[a] <= lane(grav_q, a) - round_shr(
              WideW'($signed({1'b0, drag_q})) * WideW'(vel_q[a]), 10);
          end
        end
        OpVel: begin
          for (int a = 0; a < 3; a++) begin
            vn_q[a] <= sat_coord(WideW'(vel_q[a]) + round_shr(
              WideW'($signed({1'b0, hrem_q})) * acc_q[a], 16));
          end
        end
        OpPos: begin
          for (int a = 0; a < 3; a++) begin
            cn_q[a] <= WideW'(pos_q[a]) + round_shr(
              WideW'($signed({1'b0, hrem_q})) * WideW'(vn_q[a]), 16);
          end
        end
        OpHit: begin
          hit_q <= hit_d;
          face_q <= face_d;
          if (face_d[0]) begin
            num_q <= WideW'(pos_q[face_d[2:1]]) - lo_w[face_d[2:1]] - r_w;
          end else begin
            num_q <= WideW'(pos_q[face_d[2:1]]) - hi_w[face_d[2:1]] + r_w;
          end
          den_q <= WideW'(pos_q[face_d[2:1]]) - cn_q[face_d[2:1]];
        end
        OpFree: begin
          for (int a = 0; a < 3; a++) begin
            pos_q[a] <= sat_coord(cn_q[a]);
            vel_q[a] <= vn_q[a];
          end
          hrem_q <= '0;
          limit_o <= 1'b0;
        end
        OpDivInit: begin
          dzero_q <= (num_q == '0) || (den_q == '0) || (num_q[WideW-1] != den_q[WideW-1]);
          rem_q <= {17'd0, (num_q[WideW-1] ? -num_q : num_q)};
          dvs_q <= den_q[WideW-1] ? -den_q : den_q;
          quo_q <= '0;
          dcnt_q <= 6'd17;
        end
        OpDivStep: begin
          if (dcnt_q != '0) begin
            dcnt_q <= dcnt_q - 6'd1;
            if (dcnt_q == 6'd17) begin
              // integer part: at most compare once, saturation follows
              if (rem_q >= {17'd0, dvs_q}) begin
                quo_q <= 17'd1;
                rem_q <= rem_q - {17'd0, dvs_q};
              end else begin
                quo_q <= '0;
              end
            end else if (rem_try[WideW+16] == 1'b0) begin
              rem_q <= rem_try;
              quo_q <= {quo_q[15:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[15:0], 1'b0};
            end
          end
        end
        OpDt: begin
          frac_q <= dzero_q ? 17'd0 : (quo_q > 17'd65536 ? 17'd65536 : quo_q);
          dt_q <= 17'(((dzero_q ? 34'd0 : {17'd0, (quo_q > 17'd65536 ? 17'd65536 : quo_q)})
                  * {17'd0, hrem_q}) >> 16);
        end
        OpCont: begin
          for (int a = 0; a < 3; a++) begin
            vc_q[a] <= WideW'(vel_q[a]) + round_shr(
              WideW'($signed({1'b0, dt_q})) * acc_q[a], 16);
            pc_q[a] <= WideW'(pos_q[a]) + round_shr(
              WideW'($signed({1'b0, frac_q})) * (cn_q[a] - WideW'(pos_q[a])), 16);
          end
        end
        OpResp: begin
          for (int a = 0; a < 3; a++) begin
            if (2'(a) == ax) begin
              vel_q[a] <= sat_coord(-round_shr(
                WideW'($signed({1'b0, rest_s})) * vc_q[a], 10));
            end else begin
              vel_q[a] <= sat_coord(round_shr(
                WideW'($signed({1'b0, 11'd1024 - fric_s})) * vc_q[a], 10));
            end
            pos_q[a] <= sat_coord(pc_q[a]);
          end
          hrem_q <= hrem_q - dt_q;
          faces_q <= faces_q | (6'd1 << face_q);
          limit_o <= (hrem_q - dt_q) != '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      state_o[16*a +: 16] = pos_q[a];
      state_o[48+16*a +: 16] = vel_q[a];
    end
  end
  assign faces_o = faces_q;

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OpCont |-> frac_q <= 17'd65536) else $error("fraction above one");
  a_dt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OpResp |-> dt_q <= hrem_q) else $error("used time exceeds remaining");
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= 6'd17) else $error("divider count out of range");

endmodule

[hw/rtl/particle_box_collision_step_core.sv]
// ----------------------------------------------------------------------------
// particle_box_collision_step_core
// Load items go from Idle straight to Done. Advance items run up to 8 substeps,
// each using the 17-step divider when a wall is hit, until no time is left.
// Throughput: one item at a time; next item accepted once the result register
// is free. Reset restores register defaults and clears position and velocity.
// ----------------------------------------------------------------------------
module particle_box_collision_step_core import pbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [111:0]        s_axis_tdata,  // time_step, load_pos_x..z, load_vel_x..z
  input  logic                s_axis_tuser,  // func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [103:0]        m_axis_tdata,  // pos_x..z, vel_x..z, faces_hit, substep_limit
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  pbc_cmd_t cmd;
  pbc_sts_t sts;
  logic out_load;
  logic [95:0] state;
  logic [5:0] faces;
  logic limit;
  logic [103:0] res_q;
  logic res_v_q;

  pbc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_func_i(s_axis_tuser), .in_ready_o(s_axis_tready),
    .out_load_o(out_load), .out_busy_i(res_v_q),
    .cmd_o(cmd), .sts_i(sts)
  );

  pbc_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts),
    .time_step_i(s_axis_tdata[15:0]), .load_i(s_axis_tdata[111:16]),
    .state_o(state), .faces_o(faces), .limit_o(limit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (out_load) begin
      res_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= {1'b0, limit, faces, state};
    end
  end

  assign m_axis_tvalid = res_v_q;
  assign m_axis_tdata = res_q;

endmodule

[test/particle_box_collision_step_core_test.sv]
// ----------------------------------------------------------------------------
// particle_box_collision_step_core_test
// Drives load and advance items through the ball-in-box step core under
// several box, radius, gravity, restitution, friction and drag settings.
// Each accepted item is predicted in a scoreboard and checked against the
// result stream, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_box_collision_step_core_test;
  import pbc_pkg::*;

  localparam bit FuncAdvance = 1'b0;
  localparam bit FuncLoad    = 1'b1;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 250;

  typedef struct packed {
    logic [2:0][15:0] pos;
    logic [2:0][15:0] vel;
    logic [5:0]       faces;
    logic             limit;
  } step_result_t;

  class step_scoreboard;
    longint pos[3];
    longint vel[3];
    logic [47:0] box_lo_r, box_hi_r, grav_r;
    logic [13:0] radius_r, drag_r;
    logic [10:0] rest_r, fric_r;
    step_result_t pending[$];
    int errors;
    int checked;
    int hits;
    int limits;

    function new();
      box_lo_r = 48'd0;
      box_hi_r = 48'd65971704314880;
      radius_r = 14'd1024;
      grav_r   = 48'd3637313536;
      rest_r   = 11'd973;
      fric_r   = 11'd102;
      drag_r   = 14'd1024;
      for (int a = 0; a < 3; a++) begin
        pos[a] = 0;
        vel[a] = 0;
      end
      errors = 0;
      checked = 0;
      hits = 0;
      limits = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [47:0] d);
      case (idx)
        CfgBoxLow:   box_lo_r = d;
        CfgBoxHigh:  box_hi_r = d;
        CfgRadius:   radius_r = d[13:0];
        CfgGravity:  grav_r   = d;
        CfgRest:     rest_r   = d[10:0];
        CfgFriction: fric_r   = d[10:0];
        CfgDrag:     drag_r   = d[13:0];
        default: ;
      endcase
    endfunction

    function longint lane(logic [47:0] r, int a);
      logic signed [15:0] w;
      w = r[47-16*a -: 16];
      return longint'(w);
    endfunction

    function longint sat16(longint x);
      return x > 32767 ? 32767 : (x < -32768 ? -32768 : x);
    endfunction

    function longint rshr(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint contact_frac(longint num, longint den);
      longint n, d, q;
      if (num == 0 || den == 0 || ((num < 0) != (den < 0))) return 0;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = (n << 16) / d;
      return q > 65536 ? 65536 : q;
    endfunction

    function void note_item(bit func, logic [111:0] d);
      longint g[3], lo[3], hi[3], acc[3], vn[3], cn[3];
      longint r, drag, rest, fric, h, p, num, frac, dt, vc, pc;
      logic signed [15:0] w;
      int n, face, ax;
      bit hit;
      step_result_t res;
      res.faces = '0;
      res.limit = 1'b0;
      if (func == FuncLoad) begin
        for (int a = 0; a < 3; a++) begin
          w = d[16 + 16*a +: 16];
          pos[a] = longint'(w);
          w = d[64 + 16*a +: 16];
          vel[a] = longint'(w);
        end
      end else begin
        r = radius_r;
        drag = drag_r;
        rest = rest_r > 1024 ? 1024 : rest_r;
        fric = fric_r > 1024 ? 1024 : fric_r;
        h = d[15:0];
        n = 0;
        for (int a = 0; a < 3; a++) begin
          g[a] = lane(grav_r, a);
          lo[a] = lane(box_lo_r, a);
          hi[a] = lane(box_hi_r, a);
        end
        while (h != 0 && n < MaxSubsteps) begin
          face = -1;
          n++;
          for (int a = 0; a < 3; a++) begin
            acc[a] = g[a] - rshr(drag * vel[a], 10);
            vn[a] = sat16(vel[a] + rshr(h * acc[a], 16));
            cn[a] = pos[a] + rshr(h * vn[a], 16);
          end
          for (int f = 0; f < 6; f++) begin
            ax = f >> 1;
            hit = (f & 1) ? (cn[ax] - lo[ax] - r < 0) : (cn[ax] - hi[ax] + r > 0);
            if (hit) face = f;
          end
          if (face < 0) begin
            for (int a = 0; a < 3; a++) begin
              pos[a] = sat16(cn[a]);
              vel[a] = vn[a];
            end
            h = 0;
          end else begin
            ax = face >> 1;
            p = pos[ax];
            num = (face & 1) ? p - lo[ax] - r : p - hi[ax] + r;
            frac = contact_frac(num, p - cn[ax]);
            dt = (frac * h) >> 16;
            for (int a = 0; a < 3; a++) begin
              vc = vel[a] + rshr(dt * acc[a], 16);
              pc = pos[a] + rshr(frac * (cn[a] - pos[a]), 16);
              if (a == ax) vc = -rshr(rest * vc, 10);
              else vc = rshr((1024 - fric) * vc, 10);
              vel[a] = sat16(vc);
              pos[a] = sat16(pc);
            end
            h -= dt;
            res.faces[face] = 1'b1;
          end
        end
        res.limit = (h != 0);
      end
      for (int a = 0; a < 3; a++) begin
        res.pos[a] = pos[a][15:0];
        res.vel[a] = vel[a][15:0];
      end
      if (res.faces != 0) hits++;
      if (res.limit) limits++;
      pending.push_back(res);
    endfunction

    task report(string field, longint got, longint want);
      $display("mismatch on result %0d field %s: got %0h, expected %0h",
               checked, field, got, want);
      errors++;
    endtask

    task check_result(logic [103:0] d);
      step_result_t want;
      if (pending.size() == 0) begin
        report("unexpected", d[63:0], 0);
        return;
      end
      want = pending.pop_front();
      for (int a = 0; a < 3; a++) begin
        if (d[16*a +: 16] !== want.pos[a]) report($sformatf("pos[%0d]", a),
                                                 d[16*a +: 16], want.pos[a]);
        if (d[48 + 16*a +: 16] !== want.vel[a]) report($sformatf("vel[%0d]", a),
                                                       d[48 + 16*a +: 16], want.vel[a]);
      end
      if (d[101:96] !== want.faces) report("faces_hit", d[101:96], want.faces);
      if (d[102] !== want.limit) report("substep_limit", d[102], want.limit);
      checked++;
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [111:0]        s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [103:0]        m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  step_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned loads_sent = 0;
  bit busy_tx = 1'b1;
  bit busy_rx = 1'b1;
  int stall = 0;

  particle_box_collision_step_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("particle_box_collision_step_core_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(negedge clk_i) begin
    if (stall > 0) begin
      m_axis_tready = 1'b0;
      stall--;
    end else begin
      m_axis_tready = 1'b1;
      if (busy_rx && $urandom_range(0, 3) == 0)
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    end
  end

  task send_item(bit func, logic [111:0] d);
    int gap;
    gap = 0;
    if (busy_tx && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = func;
    s_axis_tdata  = d;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    sb.note_item(func, d);
    items_sent++;
    if (func == FuncLoad) loads_sent++;
  endtask

  task load(logic [2:0][15:0] p, logic [2:0][15:0] v);
    send_item(FuncLoad, {v[2], v[1], v[0], p[2], p[1], p[0], 16'($urandom)});
  endtask

  task advance(logic [15:0] h);
    send_item(FuncAdvance, {96'({$urandom, $urandom, $urandom}), h});
  endtask

  task drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task write_cfg(logic [CfgIdxW-1:0] idx, logic [47:0] d);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = d;
    sb.write_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function logic [15:0] rand_between(longint lo, longint hi);
    if (hi <= lo) return 16'($urandom);
    return 16'(lo + longint'($urandom_range(0, 32'(hi - lo))));
  endfunction

  task run_phase(int n);
    logic [2:0][15:0] p, v;
    longint lo, hi, r;
    int left;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) load(96'({$urandom, $urandom, $urandom}),
                                       96'({$urandom, $urandom, $urandom}));
        else advance(16'($urandom));
        left--;
      end else begin
        r = sb.radius_r;
        for (int a = 0; a < 3; a++) begin
          lo = sb.lane(sb.box_lo_r, a) + r;
          hi = sb.lane(sb.box_hi_r, a) - r;
          p[a] = rand_between(lo, hi);
          v[a] = 16'($urandom_range(0, 8191)) - 16'd4096;
          if ($urandom_range(0, 4) == 0) v[a] = 16'($urandom);
        end
        load(p, v);
        left--;
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) advance(16'($urandom));
          else advance(16'($urandom_range(1, 8191)));
          left--;
        end
      end
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = FuncAdvance;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgBoxLow;
    cfg_data_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    advance(16'd0);
    advance(16'd6554);
    load({3{16'h7fff}}, {3{16'h7fff}});
    advance(16'd1000);
    load({3{16'h8000}}, {3{16'h8000}});
    advance(16'hffff);
    load({3{16'd7680}}, {3{16'd0}});
    advance(16'd0);
    advance(16'hffff);
    load({16'd7680, 16'd7680, 16'd14000}, {16'd0, 16'd0, 16'd30000});
    advance(16'd4000);
    load({16'd7680, 16'd1100, 16'd7680}, {16'd0, 16'h8100, 16'd0});
    advance(16'd3000);
    load({16'd14000, 16'd7680, 16'd7680}, {16'd0, 16'd0, 16'h8000});
    advance(16'd8000);
    load({16'd7680, 16'd7680, 16'h8000}, {16'd100, 16'd100, 16'd100});
    advance(16'd1);
    advance(16'hffff);
    drain();

    run_phase(90);

    write_cfg(CfgBoxLow,   {3{16'hf800}});
    write_cfg(CfgBoxHigh,  {3{16'h0800}});
    write_cfg(CfgRadius,   48'd512);
    write_cfg(CfgGravity,  {16'd300, 16'hd8c9, 16'hff00});
    write_cfg(CfgRest,     48'd1024);
    write_cfg(CfgFriction, 48'd0);
    write_cfg(CfgDrag,     48'd0);
    run_phase(100);

    busy_tx = 1'b0;
    busy_rx = 1'b0;
    write_cfg(CfgBoxLow,   {3{16'h8000}});
    write_cfg(CfgBoxHigh,  {3{16'h7fff}});
    write_cfg(CfgRadius,   48'd1);
    write_cfg(CfgRest,     48'd0);
    write_cfg(CfgFriction, 48'd1024);
    write_cfg(CfgDrag,     48'd16383);
    run_phase(80);

    busy_tx = 1'b1;
    busy_rx = 1'b1;
    write_cfg(CfgBoxLow,   {3{16'hc000}});
    write_cfg(CfgBoxHigh,  {3{16'h4000}});
    write_cfg(CfgRadius,   48'd16383);
    write_cfg(CfgGravity,  {16'h8000, 16'h7fff, 16'h8000});
    write_cfg(CfgRest,     48'd2047);
    write_cfg(CfgFriction, 48'd2047);
    write_cfg(CfgDrag,     48'($urandom_range(0, 16383)));
    run_phase(80);

    repeat (2) begin
      write_cfg(CfgBoxLow,   {16'($urandom_range(0, 8191)) - 16'd8192,
                              16'($urandom_range(0, 8191)) - 16'd8192,
                              16'($urandom_range(0, 8191)) - 16'd8192});
      write_cfg(CfgBoxHigh,  {16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)),
                              16'($urandom_range(0, 8191))});
      write_cfg(CfgRadius,   48'($urandom_range(1, 3000)));
      write_cfg(CfgGravity,  48'({$urandom, $urandom}));
      write_cfg(CfgRest,     48'($urandom_range(0, 2047)));
      write_cfg(CfgFriction, 48'($urandom_range(0, 2047)));
      write_cfg(CfgDrag,     48'($urandom_range(0, 16383)));
      run_phase(90);
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d items (%0d loads), checked %0d results", items_sent, loads_sent,
             sb.checked);
    $display("%0d results with wall contact, %0d ran out of substeps", sb.hits, sb.limits);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("particle_box_collision_step_core_test OK");
    end else begin
      $display("particle_box_collision_step_core_test NOT OK");
    end
    $finish;
  end

endmodule
